// ===== hdl/dopl_pkg.sv =====
// shared types, widths and constants for the open-page latency model
`default_nettype none
package dopl_pkg;

  localparam int ADDR_W    = 15;
  localparam int LAT_W     = 10;
  localparam int RESP_W    = 11;
  localparam int BANK_W    = 3;
  localparam int ROW_W     = 4;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_BANKS = 1 << BANK_W;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int Q_CNT_W   = 2;

  localparam logic [LAT_W-1:0] HIT_LAT_RST   = LAT_W'(20);
  localparam logic [LAT_W-1:0] MISS_LAT_RST  = LAT_W'(200);
  localparam logic [LAT_W-1:0] RD_PATH_RST   = LAT_W'(30);
  localparam logic [LAT_W-1:0] WR_PATH_RST   = LAT_W'(30);
  localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIT_LAT  = 3'd0,
    REG_MISS_LAT = 3'd1,
    REG_RD_PATH  = 3'd2,
    REG_WR_PATH  = 3'd3
  } cfg_reg_t;

  // classified access passed from front to back
  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [ROW_W-1:0]  row;
    logic              is_write;
  } req_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/dopl_front.sv =====
// front end: accepts accesses and slices the address into bank and row
`default_nettype none
module dopl_front #(
  parameter int unsigned COL_BITS     = 8,
  parameter int unsigned ROW_BITS     = 4,
  parameter int unsigned BANK_BITS    = 1,
  parameter int unsigned RANK_BITS    = 1,
  parameter int unsigned CHANNEL_BITS = 1
) (
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [dopl_pkg::ADDR_W-1:0] in_address,
  input  wire logic                        in_is_write,
  input  wire logic                        q_full,
  output logic                             busy,
  output logic                             push,
  output dopl_pkg::req_t                   req
);

  localparam int EXT_W = dopl_pkg::ADDR_W + COL_BITS + ROW_BITS + BANK_BITS
                         + RANK_BITS + CHANNEL_BITS;
  localparam int ROW_POS   = COL_BITS;
  localparam int FLAT_POS  = COL_BITS + ROW_BITS;
  localparam int FLAT_BITS = BANK_BITS + RANK_BITS + CHANNEL_BITS;

  logic [EXT_W-1:0] addr_ext;
  logic [EXT_W-1:0] row_field;
  logic [EXT_W-1:0] flat_field;

  // channel, rank and bank sit next to each other, so the flat index is one field
  always_comb begin
    addr_ext   = EXT_W'(in_address);
    row_field  = addr_ext >> ROW_POS;
    flat_field = addr_ext >> FLAT_POS;
    for (int i = 0; i < EXT_W; i++) begin
      if (i >= ROW_BITS) row_field[i] = 1'b0;
      if (i >= FLAT_BITS) flat_field[i] = 1'b0;
    end
    req.bank     = flat_field[dopl_pkg::BANK_W-1:0];
    req.row      = row_field[dopl_pkg::ROW_W-1:0];
    req.is_write = in_is_write;
  end

  assign busy = !rst_n || q_full;
  assign push = start && !busy;

endmodule
`default_nettype wire

// ===== hdl/dopl_queue.sv =====
// short word queue between front and back
`default_nettype none
module dopl_queue (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire dopl_pkg::req_t push_word,
  input  wire logic     pop,
  output dopl_pkg::req_t pop_word,
  output logic          full,
  output logic          not_empty
);

  dopl_pkg::req_t mem [dopl_pkg::Q_DEPTH];

  logic [dopl_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [dopl_pkg::Q_CNT_W-1:0] count_r, count_nxt;

  logic do_push, do_pop;

  assign full      = (count_r == dopl_pkg::Q_CNT_W'(dopl_pkg::Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_word  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + dopl_pkg::Q_CNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - dopl_pkg::Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + dopl_pkg::Q_PTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + dopl_pkg::Q_PTR_W'(1);
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dopl_back.sv =====
// back end: row buffer table, latency registers, totals and result register
`default_nettype none
module dopl_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [dopl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dopl_pkg::LAT_W-1:0]     cfg_data,
  input  wire logic                           req_valid,
  input  wire dopl_pkg::req_t                 req,
  output logic                                pop,
  output logic                                out_valid,
  output logic [dopl_pkg::RESP_W-1:0]         out_response_cycles,
  output logic                                out_page_hit,
  output logic [dopl_pkg::BANK_W-1:0]         out_bank_select,
  output logic [dopl_pkg::ROW_W-1:0]          out_row_number,
  output logic [dopl_pkg::CNT_W-1:0]          out_total_hits,
  output logic [dopl_pkg::CNT_W-1:0]          out_total_misses,
  output logic [dopl_pkg::CNT_W-1:0]          out_total_reads,
  output logic [dopl_pkg::CNT_W-1:0]          out_total_writes
);

  logic [dopl_pkg::LAT_W-1:0] hit_lat_r, miss_lat_r, rd_path_r, wr_path_r;

  logic [dopl_pkg::ROW_W-1:0] open_row_r [dopl_pkg::NUM_BANKS];
  logic [dopl_pkg::NUM_BANKS-1:0] row_valid_r;

  logic [dopl_pkg::CNT_W-1:0] hits_r, misses_r, reads_r, writes_r;
  logic [dopl_pkg::CNT_W-1:0] hits_nxt, misses_nxt, reads_nxt, writes_nxt;

  logic                        out_valid_r;
  logic [dopl_pkg::RESP_W-1:0] resp_r, resp_nxt;
  logic                        hit_r, hit_nxt;
  logic [dopl_pkg::BANK_W-1:0] bank_r;
  logic [dopl_pkg::ROW_W-1:0]  row_r;

  logic [dopl_pkg::LAT_W-1:0] path_lat, page_lat;

  // the back never stalls, so it drains one word per cycle
  assign pop = req_valid;

  always_comb begin
    hit_nxt    = row_valid_r[req.bank] && (open_row_r[req.bank] == req.row);
    path_lat   = req.is_write ? wr_path_r : rd_path_r;
    page_lat   = hit_nxt ? hit_lat_r : miss_lat_r;
    resp_nxt   = dopl_pkg::RESP_W'(path_lat) + dopl_pkg::RESP_W'(page_lat);
    hits_nxt   = hit_nxt ? dopl_pkg::sat_inc(hits_r) : hits_r;
    misses_nxt = hit_nxt ? misses_r : dopl_pkg::sat_inc(misses_r);
    writes_nxt = req.is_write ? dopl_pkg::sat_inc(writes_r) : writes_r;
    reads_nxt  = req.is_write ? reads_r : dopl_pkg::sat_inc(reads_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_lat_r <= dopl_pkg::HIT_LAT_RST;
      miss_lat_r <= dopl_pkg::MISS_LAT_RST;
      rd_path_r <= dopl_pkg::RD_PATH_RST;
      wr_path_r <= dopl_pkg::WR_PATH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dopl_pkg::REG_HIT_LAT:  hit_lat_r  <= cfg_data;
        dopl_pkg::REG_MISS_LAT: miss_lat_r <= cfg_data;
        dopl_pkg::REG_RD_PATH:  rd_path_r  <= cfg_data;
        dopl_pkg::REG_WR_PATH:  wr_path_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // open rows; a closed bank is marked by its valid bit
  always_ff @(posedge clk) begin
    if (req_valid && !hit_nxt) open_row_r[req.bank] <= req.row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      reads_r     <= '0;
      writes_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= req_valid;
      if (req_valid) begin
        row_valid_r[req.bank] <= 1'b1;
        hits_r   <= hits_nxt;
        misses_r <= misses_nxt;
        reads_r  <= reads_nxt;
        writes_r <= writes_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      resp_r <= resp_nxt;
      hit_r  <= hit_nxt;
      bank_r <= req.bank;
      row_r  <= req.row;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_response_cycles = resp_r;
  assign out_page_hit        = hit_r;
  assign out_bank_select     = bank_r;
  assign out_row_number      = row_r;
  assign out_total_hits      = hits_r;
  assign out_total_misses    = misses_r;
  assign out_total_reads     = reads_r;
  assign out_total_writes    = writes_r;

endmodule
`default_nettype wire

// ===== hdl/dram_open_page_latency_model.sv =====
// top level of the open-page dram latency model
//
// usage:
//   an access word (in_address, in_is_write) is taken at a rising edge where
//   start is high and busy is low. the front slices the address into a flat
//   bank index and a row and places the word in a two-entry queue; the back
//   looks up the bank's open row, updates it and the totals, and registers
//   the result.
//   the accepted word is written into the queue, and the back then registers
//   the result and raises the result strobe out_valid.
//   throughput: one access per cycle, set by the row compare and update in
//   the back, which never stalls; busy stays low in normal operation.
//   results are shown for exactly one cycle; the receiver cannot stall them.
//   configuration: cfg_we writes cfg_data into latency register cfg_index
//   (0 hit, 1 miss, 2 read path, 3 write path); other indexes are ignored.
//   reset (rst_n low, synchronous) closes all rows, clears the totals,
//   restores the latency defaults and holds busy high.
`default_nettype none
module dram_open_page_latency_model #(
  parameter int unsigned COL_BITS     = 8,
  parameter int unsigned ROW_BITS     = 4,
  parameter int unsigned BANK_BITS    = 1,
  parameter int unsigned RANK_BITS    = 1,
  parameter int unsigned CHANNEL_BITS = 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [dopl_pkg::ADDR_W-1:0]    in_address,
  input  wire logic                           in_is_write,
  input  wire logic                           cfg_we,
  input  wire logic [dopl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dopl_pkg::LAT_W-1:0]     cfg_data,
  output logic                                out_valid,
  output logic [dopl_pkg::RESP_W-1:0]         out_response_cycles,
  output logic                                out_page_hit,
  output logic [dopl_pkg::BANK_W-1:0]         out_bank_select,
  output logic [dopl_pkg::ROW_W-1:0]          out_row_number,
  output logic [dopl_pkg::CNT_W-1:0]          out_total_hits,
  output logic [dopl_pkg::CNT_W-1:0]          out_total_misses,
  output logic [dopl_pkg::CNT_W-1:0]          out_total_reads,
  output logic [dopl_pkg::CNT_W-1:0]          out_total_writes
);

  dopl_pkg::req_t front_req, back_req;
  logic push, pop, q_full, q_not_empty;

  dopl_front #(
    .COL_BITS    (COL_BITS),
    .ROW_BITS    (ROW_BITS),
    .BANK_BITS   (BANK_BITS),
    .RANK_BITS   (RANK_BITS),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_front (
    .rst_n      (rst_n),
    .start      (start),
    .in_address (in_address),
    .in_is_write(in_is_write),
    .q_full     (q_full),
    .busy       (busy),
    .push       (push),
    .req        (front_req)
  );

  dopl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_word(front_req),
    .pop      (pop),
    .pop_word (back_req),
    .full     (q_full),
    .not_empty(q_not_empty)
  );

  dopl_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .req_valid          (q_not_empty),
    .req                (back_req),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_response_cycles(out_response_cycles),
    .out_page_hit       (out_page_hit),
    .out_bank_select    (out_bank_select),
    .out_row_number     (out_row_number),
    .out_total_hits     (out_total_hits),
    .out_total_misses   (out_total_misses),
    .out_total_reads    (out_total_reads),
    .out_total_writes   (out_total_writes)
  );

endmodule
`default_nettype wire

// ===== hdl/dopl_chk.sv =====
// port-level checker for the open-page latency model, bound to the top level
`default_nettype none
module dopl_chk (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       out_valid,
  input wire logic                       out_page_hit,
  input wire logic [dopl_pkg::CNT_W-1:0] out_total_hits,
  input wire logic [dopl_pkg::CNT_W-1:0] out_total_misses
);

  // every accepted word comes out as a result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted word produced no result");

  // no result without an accepted word before it
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted word");

  // the back drains every cycle, so the queue never backs up
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

  // the total of the reported outcome includes this word
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_page_hit) |-> (out_total_hits != '0))
    else $error("page hit with zero hit total");

  a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_page_hit) |-> (out_total_misses != '0))
    else $error("page miss with zero miss total");

endmodule

bind dram_open_page_latency_model dopl_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_page_hit    (out_page_hit),
  .out_total_hits  (out_total_hits),
  .out_total_misses(out_total_misses)
);
`default_nettype wire

// ===== dv/dram_open_page_latency_model_tb.sv =====
// testbench for the open-page dram latency model: directed table, then random phases
`timescale 1ns / 100ps
module dram_open_page_latency_model_tb;

  localparam int unsigned COL_BITS     = 8;
  localparam int unsigned ROW_BITS     = 4;
  localparam int unsigned BANK_BITS    = 1;
  localparam int unsigned RANK_BITS    = 1;
  localparam int unsigned CHANNEL_BITS = 1;

  localparam int ADDR_W    = dopl_pkg::ADDR_W;
  localparam int LAT_W     = dopl_pkg::LAT_W;
  localparam int RESP_W    = dopl_pkg::RESP_W;
  localparam int BANK_W    = dopl_pkg::BANK_W;
  localparam int ROW_W     = dopl_pkg::ROW_W;
  localparam int CNT_W     = dopl_pkg::CNT_W;
  localparam int CFG_IDX_W = dopl_pkg::CFG_IDX_W;
  localparam int NUM_BANKS = dopl_pkg::NUM_BANKS;

  localparam int NUM_REGS      = int'(dopl_pkg::REG_WR_PATH) + 1;
  localparam int NUM_CFG_SLOTS = 1 << CFG_IDX_W;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 125;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [RESP_W-1:0] cycles;
    logic              page_hit;
    logic [BANK_W-1:0] bank;
    logic [ROW_W-1:0]  row;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  misses;
    logic [CNT_W-1:0]  reads;
    logic [CNT_W-1:0]  writes;
  } access_result_t;

  typedef enum logic {STEP_ACCESS, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t         kind;
    logic [ADDR_W-1:0]  addr;
    logic               is_write;
    logic [CFG_IDX_W-1:0] idx;
    logic [LAT_W-1:0]   data;
    logic               typed;
    logic [RESP_W-1:0]  exp_cycles;
    logic               exp_hit;
    logic [BANK_W-1:0]  exp_bank;
    logic [ROW_W-1:0]   exp_row;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [ADDR_W-1:0] in_address = '0;
  logic in_is_write = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LAT_W-1:0] cfg_data = '0;
  logic out_valid;
  logic [RESP_W-1:0] out_response_cycles;
  logic out_page_hit;
  logic [BANK_W-1:0] out_bank_select;
  logic [ROW_W-1:0] out_row_number;
  logic [CNT_W-1:0] out_total_hits;
  logic [CNT_W-1:0] out_total_misses;
  logic [CNT_W-1:0] out_total_reads;
  logic [CNT_W-1:0] out_total_writes;

  // shadow copy of the block's configuration and bank state
  logic [LAT_W-1:0] lat_hit;
  logic [LAT_W-1:0] lat_miss;
  logic [LAT_W-1:0] lat_read;
  logic [LAT_W-1:0] lat_write;
  logic [ROW_W-1:0] open_row_q [NUM_BANKS];
  logic             row_valid_q [NUM_BANKS];
  logic [CNT_W-1:0] hits_q;
  logic [CNT_W-1:0] misses_q;
  logic [CNT_W-1:0] reads_q;
  logic [CNT_W-1:0] writes_q;

  access_result_t pending_results [$];
  stim_row_t      stim_table [$];
  int             mismatches = 0;
  int             stall_cycles = 0;

  dram_open_page_latency_model #(
    .COL_BITS    (COL_BITS),
    .ROW_BITS    (ROW_BITS),
    .BANK_BITS   (BANK_BITS),
    .RANK_BITS   (RANK_BITS),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_address         (in_address),
    .in_is_write        (in_is_write),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_response_cycles(out_response_cycles),
    .out_page_hit       (out_page_hit),
    .out_bank_select    (out_bank_select),
    .out_row_number     (out_row_number),
    .out_total_hits     (out_total_hits),
    .out_total_misses   (out_total_misses),
    .out_total_reads    (out_total_reads),
    .out_total_writes   (out_total_writes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
  endfunction

  function automatic void clear_model();
    lat_hit   = dopl_pkg::HIT_LAT_RST;
    lat_miss  = dopl_pkg::MISS_LAT_RST;
    lat_read  = dopl_pkg::RD_PATH_RST;
    lat_write = dopl_pkg::WR_PATH_RST;
    for (int b = 0; b < NUM_BANKS; b++) begin
      open_row_q[b]  = '0;
      row_valid_q[b] = 1'b0;
    end
    hits_q   = '0;
    misses_q = '0;
    reads_q  = '0;
    writes_q = '0;
  endfunction

  function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [LAT_W-1:0] data);
    case (idx)
      dopl_pkg::REG_HIT_LAT:  lat_hit = data;
      dopl_pkg::REG_MISS_LAT: lat_miss = data;
      dopl_pkg::REG_RD_PATH:  lat_read = data;
      dopl_pkg::REG_WR_PATH:  lat_write = data;
      default: ;
    endcase
  endfunction

  // slices the address, looks up the bank's open row and updates the totals
  function automatic access_result_t predict_access(input logic [ADDR_W-1:0] addr,
                                                    input logic wr);
    access_result_t r;
    int unsigned a;
    int unsigned row;
    int unsigned bk;
    int unsigned rk;
    int unsigned ch;
    int unsigned flat;
    a    = 32'(addr);
    row  = (a >> COL_BITS) & ((1 << ROW_BITS) - 1);
    bk   = (a >> (COL_BITS + ROW_BITS)) & ((1 << BANK_BITS) - 1);
    rk   = (a >> (COL_BITS + ROW_BITS + BANK_BITS)) & ((1 << RANK_BITS) - 1);
    ch   = (a >> (COL_BITS + ROW_BITS + BANK_BITS + RANK_BITS))
           & ((1 << CHANNEL_BITS) - 1);
    flat = (ch << (RANK_BITS + BANK_BITS)) | (rk << BANK_BITS) | bk;
    r.bank = BANK_W'(flat);
    r.row  = ROW_W'(row);
    if (wr) begin
      writes_q = bump(writes_q);
      r.cycles = RESP_W'(lat_write);
    end else begin
      reads_q  = bump(reads_q);
      r.cycles = RESP_W'(lat_read);
    end
    r.page_hit = row_valid_q[r.bank] && (open_row_q[r.bank] == r.row);
    if (r.page_hit) begin
      hits_q   = bump(hits_q);
      r.cycles = r.cycles + RESP_W'(lat_hit);
    end else begin
      misses_q = bump(misses_q);
      open_row_q[r.bank]  = r.row;
      row_valid_q[r.bank] = 1'b1;
      r.cycles = r.cycles + RESP_W'(lat_miss);
    end
    r.hits   = hits_q;
    r.misses = misses_q;
    r.reads  = reads_q;
    r.writes = writes_q;
    return r;
  endfunction

  function automatic void add_access(input logic [ADDR_W-1:0] addr, input logic wr,
                                     input logic typed, input int unsigned cyc,
                                     input int unsigned hit, input int unsigned bank,
                                     input int unsigned row);
    stim_row_t s;
    s = '0;
    s.kind       = STEP_ACCESS;
    s.addr       = addr;
    s.is_write   = wr;
    s.typed      = typed;
    s.exp_cycles = RESP_W'(cyc);
    s.exp_hit    = hit[0];
    s.exp_bank   = BANK_W'(bank);
    s.exp_row    = ROW_W'(row);
    stim_table.push_back(s);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [LAT_W-1:0] data);
    stim_row_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.idx  = idx;
    s.data = data;
    stim_table.push_back(s);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LAT_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    store_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_access(input stim_row_t s);
    access_result_t r;
    @(negedge clk);
    start       <= 1'b1;
    in_address  <= s.addr;
    in_is_write <= s.is_write;
    do @(posedge clk); while (busy);
    r = predict_access(s.addr, s.is_write);
    // hand-typed rows override the predicted cycles, page hit, bank and row fields
    if (s.typed) begin
      r.cycles   = s.exp_cycles;
      r.page_hit = s.exp_hit;
      r.bank     = s.exp_bank;
      r.row      = s.exp_row;
    end
    pending_results.push_back(r);
  endtask

  // start is held low before the next word is driven, for a span set by n
  task automatic idle_cycles(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    access_result_t e;
    if (out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: result word with nothing expected, cycles %0d",
                   out_response_cycles);
      end else begin
        e = pending_results.pop_front();
        check_field("response_cycles", CNT_W'(e.cycles), CNT_W'(out_response_cycles));
        check_field("page_hit", CNT_W'(e.page_hit), CNT_W'(out_page_hit));
        check_field("bank_select", CNT_W'(e.bank), CNT_W'(out_bank_select));
        check_field("row_number", CNT_W'(e.row), CNT_W'(out_row_number));
        check_field("total_hits", e.hits, out_total_hits);
        check_field("total_misses", e.misses, out_total_misses);
        check_field("total_reads", e.reads, out_total_reads);
        check_field("total_writes", e.writes, out_total_writes);
      end
    end
  end

  // cycles with no word taken on any port
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    stim_row_t acc;
    bit idle_on;
    logic [LAT_W-1:0] v;
    clear_model();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset latencies: hit 20, miss 200, both paths 30
    add_access(15'h0000, 1'b0, 1'b1, 230, 0, 0, 0);
    add_access(15'h0000, 1'b0, 1'b1, 50, 1, 0, 0);
    add_access(15'h7fff, 1'b1, 1'b1, 230, 0, 7, 15);
    add_access(15'h7fff, 1'b1, 1'b1, 50, 1, 7, 15);
    add_access(15'h00ff, 1'b0, 1'b1, 50, 1, 0, 0);   // column bits play no part
    add_access(15'h0100, 1'b0, 1'b1, 230, 0, 0, 1);
    add_access(15'h0000, 1'b0, 1'b1, 230, 0, 0, 0);  // row was replaced
    add_access(15'h1000, 1'b1, 1'b1, 230, 0, 1, 0);  // closed bank, row equals reset row
    add_access(15'h2000, 1'b1, 1'b1, 230, 0, 2, 0);
    add_access(15'h4000, 1'b1, 1'b1, 230, 0, 4, 0);
    add_cfg(dopl_pkg::REG_HIT_LAT, '0);
    add_cfg(dopl_pkg::REG_MISS_LAT, '0);
    add_cfg(dopl_pkg::REG_RD_PATH, '0);
    add_cfg(dopl_pkg::REG_WR_PATH, '0);
    add_access(15'h0000, 1'b0, 1'b1, 0, 1, 0, 0);
    add_access(15'h0a00, 1'b1, 1'b1, 0, 0, 0, 10);
    add_cfg(dopl_pkg::REG_HIT_LAT, '1);
    add_cfg(dopl_pkg::REG_MISS_LAT, '1);
    add_cfg(dopl_pkg::REG_RD_PATH, '1);
    add_cfg(dopl_pkg::REG_WR_PATH, '1);
    add_access(15'h0a00, 1'b1, 1'b1, 2046, 1, 0, 10);
    add_access(15'h3500, 1'b0, 1'b1, 2046, 0, 3, 5);
    // unknown indexes must leave the latencies alone
    for (int i = NUM_REGS; i < NUM_CFG_SLOTS; i++) add_cfg(CFG_IDX_W'(i), '0);
    add_access(15'h3500, 1'b0, 1'b1, 2046, 1, 3, 5);
    add_cfg(dopl_pkg::REG_HIT_LAT, 10'd7);
    add_cfg(dopl_pkg::REG_WR_PATH, 10'd5);
    add_access(15'h3500, 1'b1, 1'b1, 12, 1, 3, 5);
    add_access(15'h5a5a, 1'b0, 1'b0, 0, 0, 0, 0);
    add_access(15'h6c3e, 1'b1, 1'b0, 0, 0, 0, 0);

    foreach (stim_table[k]) begin
      if (stim_table[k].kind == STEP_CFG) begin
        drain_results();
        write_reg(stim_table[k].idx, stim_table[k].data);
      end else begin
        send_access(stim_table[k]);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      for (int r = 0; r < NUM_REGS; r++) begin
        if (p == 0) v = '0;
        else if (p == 1) v = '1;
        else v = LAT_W'($urandom_range(0, (1 << LAT_W) - 1));
        write_reg(CFG_IDX_W'(r), v);
      end
      if (p >= 2)
        write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, NUM_CFG_SLOTS - 1)), LAT_W'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        idle_on = (p < PHASES - 1) && (i < 100);
        if (idle_on && $urandom_range(0, 5) == 0) idle_cycles($urandom_range(1, 14));
        acc = '0;
        acc.kind     = STEP_ACCESS;
        acc.addr     = ADDR_W'($urandom);
        acc.is_write = 1'($urandom_range(0, 1));
        // mostly two rows per bank so hits and row swaps both come often
        if ($urandom_range(0, 3) != 0)
          acc.addr[COL_BITS +: ROW_BITS] = ROW_BITS'($urandom_range(0, 1));
        send_access(acc);
      end
    end

    drain_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dopl_pkg.sv
hdl/dopl_front.sv
hdl/dopl_queue.sv
hdl/dopl_back.sv
hdl/dram_open_page_latency_model.sv
hdl/dopl_chk.sv
dv/dram_open_page_latency_model_tb.sv
